[rtl/core/srtf_tick_scheduler_macros.svh]
// ----------------------------------------------------------------------------
// SRTF tick scheduler assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SRTF_TICK_SCHEDULER_MACROS_SVH
`define SRTF_TICK_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define SRTF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define SRTF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SRTF_ASSERT_IMP(label, ante, cons, msg)
`define SRTF_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[rtl/core/srtf_pkg.sv]
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Table size, field widths, stream word layout and command codes.
// ----------------------------------------------------------------------------
package srtf_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

    localparam int CMD_W  = 2;
    localparam int SLOT_W = 4;
    localparam int TIME_W = 16;

    // Table entry: {arrival, initial burst, remaining}
    localparam int ENTRY_W = 3 * TIME_W;

    localparam int S_TDATA_W = ((SLOT_W + 2 * TIME_W + 7) / 8) * 8;
    localparam int S_TUSER_W = CMD_W;
    localparam int M_TDATA_W = ((SLOT_W + TIME_W + 1 + 7) / 8) * 8;
    localparam int M_TUSER_W = 1;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_LOAD  = 2'd0;
    localparam cmd_t CMD_TICK  = 2'd1;
    localparam cmd_t CMD_CLEAR = 2'd2;

endpackage

[rtl/core/srtf_tick_scheduler.sv]
// ----------------------------------------------------------------------------
// SRTF tick scheduler
// Preemptive shortest-remaining-time-first selection over a process table.
// ----------------------------------------------------------------------------
// A load word writes one table slot and a clear word empties the table and
// zeroes the clock. A tick word is accepted, then each slot is read in turn
// through the table's single synchronous read port, a last state finishes the
// final compare, and a write state writes back the chosen entry and presents
// the result, waiting there until the output register is free. The table
// is a single memory and the valid bits are flip-flops, so no clearing pass
// is needed after reset or a clear. A result waits in the output register
// while load and clear words continue to be taken.
module srtf_tick_scheduler
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // slot [3:0], burst [19:4], arrival [35:20], zero pad
    input  logic [srtf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // command [1:0]
    input  logic [srtf_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // ran_slot [3:0], tick_time [19:4], all_done [20], zero pad
    output logic [srtf_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // idle [0]
    output logic [srtf_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    import srtf_pkg::*;

`include "srtf_tick_scheduler_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_WRITE
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);

    // Table memory
    logic [ENTRY_W-1:0] mem [MAX_PROCS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    // Control and selection registers
    state_t                state_reg,      state_next;
    logic [IDX_W-1:0]      scan_idx_reg,   scan_idx_next;
    logic                  cmp_vld_reg,    cmp_vld_next;
    logic [IDX_W-1:0]      cmp_idx_reg,    cmp_idx_next;
    logic [MAX_PROCS-1:0]  valid_reg,      valid_next;
    logic [TIME_W-1:0]     clock_reg,      clock_next;
    logic                  found_reg,      found_next;
    logic [IDX_W-1:0]      best_idx_reg,   best_idx_next;
    logic [TIME_W-1:0]     best_rem_reg,   best_rem_next;
    logic [TIME_W-1:0]     best_burst_reg, best_burst_next;
    logic [TIME_W-1:0]     best_arr_reg,   best_arr_next;
    logic [1:0]            active_cnt_reg, active_cnt_next;
    logic                  out_valid_reg,  out_valid_next;
    logic [M_TDATA_W-1:0]  out_data_reg,   out_data_next;
    logic [M_TUSER_W-1:0]  out_user_reg,   out_user_next;

    // Input word fields
    cmd_t              cmd_in;
    logic [SLOT_W-1:0] slot_in;
    logic [TIME_W-1:0] burst_in;
    logic [TIME_W-1:0] arr_in;
    logic              slot_in_range;
    logic              in_accept;

    // Compare stage
    logic [TIME_W-1:0] c_rem;
    logic [TIME_W-1:0] c_burst;
    logic [TIME_W-1:0] c_arr;
    logic              c_live;
    logic              c_ready;
    logic              c_beats;
    logic              all_done;
    logic [SLOT_W-1:0] ran_slot;
    logic              out_free;

    assign cmd_in        = s_axis_tuser[CMD_W-1:0];
    assign slot_in       = s_axis_tdata[SLOT_W-1:0];
    assign burst_in      = s_axis_tdata[SLOT_W +: TIME_W];
    assign arr_in        = s_axis_tdata[SLOT_W + TIME_W +: TIME_W];
    assign slot_in_range = (32'(slot_in) < MAX_PROCS);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    assign c_rem   = rd_data_reg[0 +: TIME_W];
    assign c_burst = rd_data_reg[TIME_W +: TIME_W];
    assign c_arr   = rd_data_reg[2 * TIME_W +: TIME_W];
    assign c_live  = valid_reg[cmp_idx_reg] && (c_rem != '0);
    assign c_ready = c_live && (clock_reg >= c_arr);
    // Strict compares keep the lower slot on a full tie
    assign c_beats = !found_reg || (c_rem < best_rem_reg) ||
                     ((c_rem == best_rem_reg) && (c_burst < best_burst_reg));

    // Done when no entry has time left, or when only the chosen entry had time left and it just ran out
    assign all_done = found_reg ? ((active_cnt_reg == 2'd1) && (best_rem_reg == TIME_W'(1)))
                                : (active_cnt_reg == 2'd0);
    assign ran_slot = found_reg ? SLOT_W'(best_idx_reg) : '0;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Memory write port: loads in idle, write-back of the chosen entry
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = best_idx_reg;
        mem_wdata = {best_arr_reg, best_burst_reg, best_rem_reg - TIME_W'(1)};
        if (state_reg == ST_IDLE)
        begin
            mem_waddr = IDX_W'(slot_in);
            mem_wdata = {arr_in, burst_in, burst_in};
            mem_we    = in_accept && (cmd_in == CMD_LOAD) && slot_in_range;
        end
        else if (state_reg == ST_WRITE)
        begin
            mem_we = found_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[scan_idx_reg];
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        valid_next      = valid_reg;
        clock_next      = clock_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_rem_next   = best_rem_reg;
        best_burst_next = best_burst_reg;
        best_arr_next   = best_arr_reg;
        active_cnt_next = active_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (cmd_in)
                        CMD_LOAD:
                        begin
                            if (slot_in_range)
                            begin
                                valid_next[IDX_W'(slot_in)] = 1'b1;
                            end
                        end
                        CMD_TICK:
                        begin
                            found_next      = 1'b0;
                            active_cnt_next = 2'd0;
                            scan_idx_next   = '0;
                            state_next      = ST_SCAN;
                        end
                        CMD_CLEAR:
                        begin
                            valid_next = '0;
                            clock_next = '0;
                        end
                        default:
                        begin
                            // drop unused command
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmp_vld_next  = 1'b1;
                cmp_idx_next  = scan_idx_reg;
                scan_idx_next = scan_idx_reg + 1'b1;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                cmp_vld_next = 1'b0;
                state_next   = ST_WRITE;
            end
            ST_WRITE:
            begin
                // hold the result and clock update until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = M_TDATA_W'({all_done, clock_reg, ran_slot});
                    out_user_next  = M_TUSER_W'(!found_reg);
                    if (clock_reg != '1)
                    begin
                        clock_next = clock_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmp_vld_reg)
        begin
            if (c_live && (active_cnt_reg != 2'd2))
            begin
                active_cnt_next = active_cnt_reg + 2'd1;
            end
            if (c_ready && c_beats)
            begin
                found_next      = 1'b1;
                best_idx_next   = cmp_idx_reg;
                best_rem_next   = c_rem;
                best_burst_next = c_burst;
                best_arr_next   = c_arr;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            valid_reg      <= '0;
            clock_reg      <= '0;
            found_reg      <= 1'b0;
            best_idx_reg   <= '0;
            best_rem_reg   <= '0;
            best_burst_reg <= '0;
            best_arr_reg   <= '0;
            active_cnt_reg <= 2'd0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_user_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            valid_reg      <= valid_next;
            clock_reg      <= clock_next;
            found_reg      <= found_next;
            best_idx_reg   <= best_idx_next;
            best_rem_reg   <= best_rem_next;
            best_burst_reg <= best_burst_next;
            best_arr_reg   <= best_arr_next;
            active_cnt_reg <= active_cnt_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_user_reg   <= out_user_next;
        end
    end

    `SRTF_ASSERT_IMP(a_no_cmp_in_idle, s_axis_tready, !cmp_vld_reg, "compare active while idle")
    `SRTF_ASSERT_IMP(a_best_live, (state_reg == ST_WRITE) && found_reg, valid_reg[best_idx_reg] && (best_rem_reg != '0), "chosen entry not live")
    `SRTF_ASSERT_IMP(a_idle_slot_zero, out_valid_reg && out_user_reg[0], out_data_reg[SLOT_W-1:0] == '0, "idle tick with nonzero slot")
    `SRTF_ASSERT_NXT(a_clock_adv, (state_reg == ST_WRITE) && out_free, (clock_reg == $past(clock_reg) + 1'b1) || ($past(clock_reg) == '1), "clock did not advance on tick")

endmodule

[tb/tb_srtf_tick_scheduler.sv]
// ----------------------------------------------------------------------------
// SRTF tick scheduler testbench
// Streams load, tick, clear and unused command words into the scheduler. A
// local model of the process table predicts every tick report, and each
// report is checked field by field in arrival order. A directed opening
// covers the corner cases. Random runs of loads and ticks follow, and a short
// back-to-back tick run closes with a late arrival preempting a long job.
// Sender gaps, receiver stalls and one long receiver hold-off vary the timing.
// ----------------------------------------------------------------------------
module tb_srtf_tick_scheduler;

    import srtf_pkg::*;

    localparam cmd_t CMD_UNUSED     = 2'd3;
    localparam int   RANDOM_WORDS   = 1000;
    localparam int   TAIL_TICKS     = 24;
    localparam int   PENDING_MAX    = 64;
    localparam int   HOLD_CYCLES    = 800;
    localparam int   HOLD_AFTER     = 150;
    localparam int   DRAIN_CYCLES   = 4 * (MAX_PROCS + 3);
    localparam int   WATCHDOG_LIMIT = 5000;
    localparam logic [TIME_W-1:0] TIME_TOP = '1;

    typedef struct {
        cmd_t              command;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] arrival;
    } sched_word_t;

    typedef struct {
        logic [SLOT_W-1:0] ran_slot;
        logic              idle;
        logic [TIME_W-1:0] tick_time;
        logic              all_done;
    } tick_report_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [S_TUSER_W-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;

    srtf_tick_scheduler dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Local copy of the process table
    logic [TIME_W-1:0] proc_remaining [MAX_PROCS];
    logic [TIME_W-1:0] proc_burst     [MAX_PROCS];
    logic [TIME_W-1:0] proc_arrival   [MAX_PROCS];
    logic              proc_valid     [MAX_PROCS];
    logic [TIME_W-1:0] sched_clock;

    sched_word_t  pending_words [$];
    tick_report_t tick_reports  [$];
    tick_report_t want;
    sched_word_t  next_word;

    logic [TIME_W-1:0] gen_clock;
    logic              steady = 1'b0;
    int                burst_left;
    int                gap_left;
    int                rx_mode;
    int                rx_left;
    logic [7:0]        rx_mask;
    int                hold_left;
    logic              hold_armed;
    int                results_seen;
    int                idle_cycles;
    int                fail_count = 0;
    int                n_load = 0;
    int                n_tick = 0;
    int                n_idle = 0;
    int                n_clear = 0;
    int                n_ignored = 0;
    int                n_saturated = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic wipe_table();
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            proc_remaining[i] = '0;
            proc_burst[i]     = '0;
            proc_arrival[i]   = '0;
            proc_valid[i]     = 1'b0;
        end
        sched_clock = '0;
    endtask

    // Apply one accepted word to the table; a tick leaves its report behind
    task automatic schedule_word(input cmd_t cmd, input logic [SLOT_W-1:0] slot,
                                 input logic [TIME_W-1:0] burst,
                                 input logic [TIME_W-1:0] arrival);
        tick_report_t rep;
        int           best;
        logic         found;
        logic         done;
        best  = 0;
        found = 1'b0;
        done  = 1'b1;
        case (cmd)
            CMD_LOAD:
            begin
                n_load++;
                if (slot < MAX_PROCS)
                begin
                    proc_remaining[slot] = burst;
                    proc_burst[slot]     = burst;
                    proc_arrival[slot]   = arrival;
                    proc_valid[slot]     = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                n_clear++;
                wipe_table();
            end
            CMD_TICK:
            begin
                n_tick++;
                // Scan upwards with strict compares so the lower slot keeps a full tie
                for (int i = 0; i < MAX_PROCS; i++)
                begin
                    if (proc_valid[i] && proc_remaining[i] != 0 &&
                        sched_clock >= proc_arrival[i])
                    begin
                        if (!found || proc_remaining[i] < proc_remaining[best] ||
                            (proc_remaining[i] == proc_remaining[best] &&
                             proc_burst[i] < proc_burst[best]))
                        begin
                            best  = i;
                            found = 1'b1;
                        end
                    end
                end
                if (found)
                    proc_remaining[best] = proc_remaining[best] - 1'b1;
                for (int i = 0; i < MAX_PROCS; i++)
                    if (proc_valid[i] && proc_remaining[i] != 0)
                        done = 1'b0;
                rep.ran_slot  = found ? SLOT_W'(best) : '0;
                rep.idle      = !found;
                rep.tick_time = sched_clock;
                rep.all_done  = done;
                if (!found)
                    n_idle++;
                if (sched_clock == TIME_TOP)
                    n_saturated++;
                else
                    sched_clock = sched_clock + 1'b1;
                tick_reports.push_back(rep);
            end
            default:
                n_ignored++;
        endcase
    endtask

    task automatic check_field(input string name, input int want_val, input int got_val);
        if (want_val != got_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want_val, got_val);
            fail_count++;
        end
    endtask

    // Hold the generator back while the driver has plenty queued
    task automatic queue_word(input cmd_t cmd, input logic [SLOT_W-1:0] slot,
                              input logic [TIME_W-1:0] burst,
                              input logic [TIME_W-1:0] arrival);
        sched_word_t w;
        while (pending_words.size() >= PENDING_MAX)
            @(negedge clk);
        w.command = cmd;
        w.slot    = slot;
        w.burst   = burst;
        w.arrival = arrival;
        pending_words.push_back(w);
        if (cmd == CMD_CLEAR)
            gen_clock = '0;
        else if (cmd == CMD_TICK && gen_clock != TIME_TOP)
            gen_clock = gen_clock + 1'b1;
    endtask

    // Driver: bursts of words separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (gap_left != 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left      <= gap_left - 1;
            end
            else if (pending_words.size() != 0)
            begin
                next_word = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= S_TDATA_W'({next_word.arrival, next_word.burst,
                                             next_word.slot});
                s_axis_tuser  <= next_word.command;
                if (burst_left <= 1)
                begin
                    burst_left <= steady ? 0 : $urandom_range(1, 40);
                    gap_left   <= (steady || $urandom_range(0, 3) == 0) ? 0 :
                                  $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // One long receiver hold-off, armed once enough reports have come back
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && results_seen >= HOLD_AFTER)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: switch between randomly chosen stall patterns
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_mode       <= 0;
            rx_left       <= 0;
            rx_mask       <= 8'b1011_0110;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode <= $urandom_range(0, 3);
                rx_left <= $urandom_range(16, 96);
            end
            else
                rx_left <= rx_left - 1;
            rx_mask <= {rx_mask[6:0], rx_mask[7]};
            if (hold_left != 0)
                m_axis_tready <= 1'b0;
            else if (steady)
                m_axis_tready <= 1'b1;
            else
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= rx_mask[0];
                endcase
        end
    end

    // Monitor: check the report first, then record the accepted input word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_seen <= 0;
            idle_cycles  <= 0;
            wipe_table();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen <= results_seen + 1;
                if (tick_reports.size() == 0)
                begin
                    $error("unexpected report: slot %0d time %0d",
                           m_axis_tdata[3:0], m_axis_tdata[19:4]);
                    fail_count++;
                end
                else
                begin
                    want = tick_reports.pop_front();
                    check_field("ran_slot", want.ran_slot, m_axis_tdata[3:0]);
                    check_field("idle", want.idle, m_axis_tuser[0]);
                    check_field("tick_time", want.tick_time, m_axis_tdata[19:4]);
                    check_field("all_done", want.all_done, m_axis_tdata[20]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                schedule_word(cmd_t'(s_axis_tuser), s_axis_tdata[3:0],
                              s_axis_tdata[19:4], s_axis_tdata[35:20]);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int                random_words;
        int                nproc;
        int                nticks;
        logic [TIME_W-1:0] b;
        logic [TIME_W-1:0] a;
        gen_clock = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Idle tick on an empty table
        queue_word(CMD_TICK, 4'd0, 16'd0, 16'd0);
        queue_word(CMD_LOAD, 4'd15, 16'hFFFF, 16'hFFFF);
        // Zero burst: valid but never runs
        queue_word(CMD_LOAD, 4'd0, 16'd0, 16'd0);
        // Idle tick with work not yet arrived
        queue_word(CMD_TICK, 4'd0, 16'd0, 16'd0);
        queue_word(CMD_LOAD, 4'd6, 16'd2, 16'd2);
        queue_word(CMD_LOAD, 4'd3, 16'd2, 16'd0);
        queue_word(CMD_TICK, 4'd0, 16'd0, 16'd0);
        queue_word(CMD_TICK, 4'd0, 16'd0, 16'd0);
        queue_word(CMD_TICK, 4'd0, 16'd0, 16'd0);
        // Equal remaining time, smaller initial burst preempts
        queue_word(CMD_LOAD, 4'd10, 16'd1, 16'd0);
        queue_word(CMD_TICK, 4'd0, 16'd0, 16'd0);
        queue_word(CMD_UNUSED, 4'd5, 16'h5A5A, 16'hA5A5);
        // Reload a slot, then a full tie that the lower slot takes
        queue_word(CMD_LOAD, 4'd6, 16'd3, 16'd0);
        queue_word(CMD_LOAD, 4'd9, 16'd3, 16'd0);
        queue_word(CMD_TICK, 4'd0, 16'd0, 16'd0);
        queue_word(CMD_CLEAR, 4'd0, 16'd0, 16'd0);
        queue_word(CMD_TICK, 4'd0, 16'd0, 16'd0);
        queue_word(CMD_LOAD, 4'd15, 16'd1, 16'd0);
        queue_word(CMD_LOAD, 4'd0, 16'd1, 16'd0);
        queue_word(CMD_TICK, 4'd0, 16'd0, 16'd0);
        queue_word(CMD_TICK, 4'd0, 16'd0, 16'd0);
        queue_word(CMD_TICK, 4'd0, 16'd0, 16'd0);

        // Random runs: a handful of loads, then enough ticks to finish most of them
        random_words = 0;
        while (random_words < RANDOM_WORDS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                queue_word(CMD_CLEAR, SLOT_W'($urandom), 16'($urandom), 16'($urandom));
                random_words++;
            end
            nproc  = $urandom_range(1, 5);
            nticks = $urandom_range(0, 4);
            for (int k = 0; k < nproc; k++)
            begin
                b = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
                a = ($urandom_range(0, 15) == 0) ? 16'($urandom) :
                    gen_clock + 16'($urandom_range(0, 8));
                nticks += (b < 16) ? int'(b) : 8;
                queue_word(CMD_LOAD, SLOT_W'($urandom_range(0, 15)), b, a);
                random_words++;
            end
            if (nticks > 48)
                nticks = 48;
            for (int k = 0; k < nticks; k++)
            begin
                case ($urandom_range(0, 19))
                    0:
                    begin
                        // Late arrival during the run, to force preemption
                        queue_word(CMD_LOAD, SLOT_W'($urandom_range(0, 15)),
                                   16'($urandom_range(1, 4)),
                                   gen_clock + 16'($urandom_range(0, 3)));
                        random_words++;
                    end
                    1:
                        queue_word(CMD_UNUSED, SLOT_W'($urandom), 16'($urandom),
                                   16'($urandom));
                    default:
                    begin
                        queue_word(CMD_TICK, SLOT_W'($urandom), 16'($urandom),
                                   16'($urandom));
                        random_words++;
                    end
                endcase
            end
        end

        // Back-to-back ticks: a late short job preempts a long one, then idle ticks
        steady = 1'b1;
        queue_word(CMD_CLEAR, 4'd0, 16'd0, 16'd0);
        queue_word(CMD_LOAD, 4'd11, 16'd12, 16'd0);
        queue_word(CMD_LOAD, 4'd4, 16'd3, 16'd5);
        for (int k = 0; k < TAIL_TICKS; k++)
            queue_word(CMD_TICK, 4'd0, 16'd0, 16'd0);

        while (pending_words.size() != 0 || s_axis_tvalid)
            @(negedge clk);
        while (tick_reports.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d loads, %0d clears, %0d ignored words and %0d ticks",
                 n_load, n_clear, n_ignored, n_tick);
        $display("%0d ticks found nothing ready, %0d ran with the clock at its top",
                 n_idle, n_saturated);
        if (fail_count == 0 && tick_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/srtf_pkg.sv
rtl/core/srtf_tick_scheduler.sv
tb/tb_srtf_tick_scheduler.sv
